### rtl/rs_pkg.sv
package rs_pkg;

    localparam int POS_W      = 32;
    localparam int RND_W      = 31;
    localparam int CAP_W      = 11;
    localparam int KEY_PORT_W = 32;
    localparam int RIDX_W     = 10;

    localparam int DEF_MAX_SLOTS = 1024;
    localparam int DEF_KEY_WIDTH = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_FETCH,
        S_EMIT
    } seq_state_t;

endpackage

### rtl/rs_ram.sv
module rs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/rs_divider.sv
module rs_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [rs_pkg::RND_W-1:0] dividend,
    input  logic [rs_pkg::POS_W:0]   divisor,
    output logic                     done,
    output logic [rs_pkg::POS_W-1:0] remainder
);

    import rs_pkg::*;

    localparam int CNT_W = $clog2(RND_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RND_W - 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RND_W-1:0] dvd_reg, dvd_next;
    logic [POS_W-1:0] rem_reg, rem_next;
    logic [POS_W:0]   dsr_reg, dsr_next;

    logic [POS_W:0] trial;
    logic [POS_W:0] diff;

    assign trial = {rem_reg, dvd_reg[RND_W-1]};
    assign diff  = trial - dsr_reg;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            rem_next = (trial >= dsr_reg) ? diff[POS_W-1:0] : trial[POS_W-1:0];
            dvd_next = {dvd_reg[RND_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### rtl/reservoir_sampler_core.sv
// Channel   Handshake                Payload
// command   start / busy             opcode, key_in, rand_value, read_index
// result    done (one-cycle strobe)  stored, slot, evicted, evicted_key,
//                                    read_key, status, occupancy
// config    cfg_valid / cfg_ready    cfg_data (sample capacity)
//
// A read in range passes through the decide, fetch and emit states after the accept
// cycle; a read out of range or an insert into a store not yet full goes from decide
// straight to emit. Once full, an insert runs the shift-subtract unit, which works one
// remainder bit per cycle over the 31 bits of rand_value; a placed insert then does one
// store read and one write, a dropped one goes to emit. busy stays high until done.
// Reset clears position, sets capacity to 1024 and idles the sequencer; store
// contents are undefined until written. The receiver cannot stall: done is one beat.
module reservoir_sampler_core #(
    parameter int MAX_SLOTS = rs_pkg::DEF_MAX_SLOTS,
    parameter int KEY_WIDTH = rs_pkg::DEF_KEY_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [rs_pkg::KEY_PORT_W-1:0] key_in,
    input  logic [rs_pkg::RND_W-1:0]      rand_value,
    input  logic [rs_pkg::RIDX_W-1:0]     read_index,
    output logic                          done,
    output logic                          stored,
    output logic [rs_pkg::CAP_W-1:0]      slot,
    output logic                          evicted,
    output logic [rs_pkg::KEY_PORT_W-1:0] evicted_key,
    output logic [rs_pkg::KEY_PORT_W-1:0] read_key,
    output logic                          status,
    output logic [rs_pkg::CAP_W-1:0]      occupancy,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rs_pkg::CAP_W-1:0]      cfg_data
);

    import rs_pkg::*;

    localparam int AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int EXT_W = KEY_WIDTH + KEY_PORT_W;

    seq_state_t state_reg, state_next;

    logic [CAP_W-1:0]      cap_reg, cap_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    op_t                   op_reg, op_next;
    logic [KEY_PORT_W-1:0] key_reg, key_next;
    logic [RND_W-1:0]      rnd_reg, rnd_next;
    logic [RIDX_W-1:0]     ridx_reg, ridx_next;
    logic [CAP_W-1:0]      pick_reg, pick_next;

    logic                  stored_reg, stored_next;
    logic [CAP_W-1:0]      slot_reg, slot_next;
    logic                  evicted_reg, evicted_next;
    logic [KEY_PORT_W-1:0] evkey_reg, evkey_next;
    logic [KEY_PORT_W-1:0] rdkey_reg, rdkey_next;
    logic                  status_reg, status_next;

    logic [CAP_W-1:0] eff_cap;
    logic [CAP_W-1:0] occ;
    logic             pos_lt_cap;
    logic             rd_in_range;
    logic             pick_hit;

    logic             div_start;
    logic             div_done;
    logic [POS_W:0]   div_divisor;
    logic [POS_W-1:0] div_rem;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [KEY_WIDTH-1:0] ram_rdata;
    logic [EXT_W-1:0]     wkey_ext;
    logic [EXT_W-1:0]     rkey_ext;
    logic [POS_W-1:0]     ridx_wide;

    assign eff_cap     = (32'(cap_reg) > MAX_SLOTS) ? CAP_W'(MAX_SLOTS) : cap_reg;
    assign pos_lt_cap  = pos_reg < POS_W'(eff_cap);
    assign occ         = pos_lt_cap ? pos_reg[CAP_W-1:0] : eff_cap;
    assign ridx_wide   = POS_W'(ridx_reg);
    assign rd_in_range = ({1'b0, ridx_reg} < occ) && (32'(ridx_reg) < MAX_SLOTS);
    assign pick_hit    = div_rem < POS_W'(eff_cap);
    assign div_divisor = {1'b0, pos_reg} + 1'b1;

    assign wkey_ext  = {{KEY_WIDTH{1'b0}}, key_reg};
    assign ram_wdata = wkey_ext[KEY_WIDTH-1:0];
    assign rkey_ext  = {{KEY_PORT_W{1'b0}}, ram_rdata};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (op_reg == OP_READ)
                begin
                    state_next = rd_in_range ? S_FETCH : S_EMIT;
                end
                else
                begin
                    state_next = pos_lt_cap ? S_EMIT : S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = pick_hit ? S_FETCH : S_EMIT;
                end
            end
            S_FETCH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = 1'b1;
        done      = 1'b0;
        cfg_ready = 1'b0;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = pos_reg[AW-1:0];
        ram_re    = 1'b0;
        ram_raddr = ridx_wide[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                busy      = 1'b0;
                cfg_ready = 1'b1;
            end
            S_DECIDE:
            begin
                if (op_reg == OP_READ)
                begin
                    ram_re = rd_in_range;
                end
                else if (pos_lt_cap)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            S_DIV:
            begin
                ram_raddr = div_rem[AW-1:0];
                ram_re    = div_done && pick_hit;
            end
            S_FETCH:
            begin
                ram_waddr = POS_W'(pick_reg) > POS_W'(0) ? AW'(POS_W'(pick_reg))
                                                           : '0;
                ram_we    = (op_reg == OP_INSERT);
            end
            S_EMIT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cap_next     = cap_reg;
        pos_next     = pos_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        rnd_next     = rnd_reg;
        ridx_next    = ridx_reg;
        pick_next    = pick_reg;
        stored_next  = stored_reg;
        slot_next    = slot_reg;
        evicted_next = evicted_reg;
        evkey_next   = evkey_reg;
        rdkey_next   = rdkey_reg;
        status_next  = status_reg;
        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = op_t'(opcode);
                    key_next  = key_in;
                    rnd_next  = rand_value;
                    ridx_next = read_index;
                end
            end
            S_DECIDE:
            begin
                stored_next  = 1'b0;
                slot_next    = '0;
                evicted_next = 1'b0;
                evkey_next   = '0;
                rdkey_next   = '0;
                status_next  = 1'b0;
                if (op_reg == OP_READ)
                begin
                    status_next = !rd_in_range;
                end
                else
                begin
                    if (pos_reg != '1)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (pos_lt_cap)
                    begin
                        stored_next = 1'b1;
                        slot_next   = pos_reg[CAP_W-1:0];
                    end
                    else
                    begin
                        slot_next = eff_cap;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pick_next = div_rem[CAP_W-1:0];
                end
            end
            S_FETCH:
            begin
                if (op_reg == OP_INSERT)
                begin
                    stored_next  = 1'b1;
                    evicted_next = 1'b1;
                    slot_next    = pick_reg;
                    evkey_next   = rkey_ext[KEY_PORT_W-1:0];
                end
                else
                begin
                    rdkey_next = rkey_ext[KEY_PORT_W-1:0];
                end
            end
            default:
            begin
                pick_next = pick_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cap_reg   <= CAP_RESET;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        rnd_reg     <= rnd_next;
        ridx_reg    <= ridx_next;
        pick_reg    <= pick_next;
        stored_reg  <= stored_next;
        slot_reg    <= slot_next;
        evicted_reg <= evicted_next;
        evkey_reg   <= evkey_next;
        rdkey_reg   <= rdkey_next;
        status_reg  <= status_next;
    end

    rs_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rnd_reg),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    rs_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (MAX_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stored      = stored_reg;
    assign slot        = slot_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evkey_reg;
    assign read_key    = rdkey_reg;
    assign status      = status_reg;
    assign occupancy   = occ;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("sequencer did not return to idle after result");

    a_evict_stored: assert property (@(posedge clk) disable iff (!rst_n)
        done && evicted |-> stored && !status)
        else $error("eviction without placement");

    a_slot_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        done && stored |-> slot < occupancy)
        else $error("placed slot not below occupancy");

    a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> !stored && !evicted && read_key == '0)
        else $error("out-of-range read carried payload");

endmodule
